FILE: sv/rri_pkg.sv
// Shared types and constants of the rectangle region index.
`timescale 1ns / 1ps
`default_nettype none
package rri_pkg;

   localparam int COORD_BITS = 12;
   localparam int ID_BITS    = 8;

   localparam logic [ID_BITS-1:0] EMPTY_MARK = 8'hFF;
   localparam logic [ID_BITS-1:0] MIXED_MARK = 8'hFE;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_REG    = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_RESERVED = 3'd1;
   localparam logic [2:0] ST_BOUNDS   = 3'd2;
   localparam logic [2:0] ST_DUP      = 3'd3;
   localparam logic [2:0] ST_OVERLAP  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef struct packed {
      logic [1:0]            kind;
      logic [ID_BITS-1:0]    region_id;
      logic [COORD_BITS-1:0] left_edge;
      logic [COORD_BITS-1:0] right_edge;
      logic [COORD_BITS-1:0] top_edge;
      logic [COORD_BITS-1:0] bottom_edge;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               found;
      logic [ID_BITS-1:0] hit_id;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] l;
      logic [COORD_BITS-1:0] r;
      logic [COORD_BITS-1:0] t;
      logic [COORD_BITS-1:0] b;
   } box_type;

   typedef struct packed {
      logic       load;
      logic       clr_begin;
      logic       clr_wr;
      logic       scan_step;
      logic       scan_acc;
      logic       append;
      logic       mark_sel;
      logic       mark_wr;
      logic       mark_step;
      logic       hit_cell;
      logic       hit_ent;
      logic       rsp_load;
      logic [2:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic bad_id;
      logic bad_bounds;
      logic cnt_zero;
      logic full;
      logic scan_last;
      logic ent_hit;
      logic dup_seen;
      logic ovl_seen;
      logic clr_last;
      logic in_grid;
      logic cell_empty;
      logic cell_mixed;
      logic mark_skip;
      logic mark_done;
   } stat_type;

endpackage
`default_nettype wire

FILE: sv/rri_dp.sv
// Datapath: request register, rectangle table, cell map memory and result register.
`timescale 1ns / 1ps
`default_nettype none
module rri_dp #(
   parameter int MAX_RECTS      = 16,
   parameter int CELL_BITS      = 6,
   parameter int CELLS_PER_AXIS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire rri_pkg::req_type req_data,
   input  wire rri_pkg::cmd_type cmd,
   output rri_pkg::stat_type     stat,
   output rri_pkg::rsp_type      rsp_data
);

   localparam int CB        = rri_pkg::COORD_BITS;
   localparam int CW        = CB - CELL_BITS;
   localparam int NUM_CELLS = CELLS_PER_AXIS * CELLS_PER_AXIS;
   localparam int AW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int IW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int NW        = $clog2(MAX_RECTS + 1);

   rri_pkg::req_type req_ff;
   rri_pkg::box_type bounds_ff [MAX_RECTS];
   logic [rri_pkg::ID_BITS-1:0] ids_ff [MAX_RECTS];
   logic [NW-1:0] count_ff;
   logic [IW-1:0] idx_ff;
   logic          dup_ff, ovl_ff, found_ff;
   logic [rri_pkg::ID_BITS-1:0] hit_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [CW-1:0] mx_ff, my_ff;
   logic [rri_pkg::ID_BITS-1:0] cell_mem [NUM_CELLS];
   logic [rri_pkg::ID_BITS-1:0] rd_ff;
   rri_pkg::rsp_type rsp_ff;

   rri_pkg::box_type ent;
   logic [CW-1:0] cx0, cx1, cy0, cy1, cx1c, cy1c, px_cell, py_cell;
   logic [AW-1:0] mark_addr, look_addr, rd_addr, wr_addr;
   logic          wr_en, whole, ent_dup, ent_ovl;
   logic [rri_pkg::ID_BITS-1:0] wr_data;
   logic [CB-1:0] xlo, xhi, ylo, yhi;

   assign ent = bounds_ff[idx_ff];
   assign cx0 = req_ff.left_edge[CB-1:CELL_BITS];
   assign cx1 = req_ff.right_edge[CB-1:CELL_BITS];
   assign cy0 = req_ff.top_edge[CB-1:CELL_BITS];
   assign cy1 = req_ff.bottom_edge[CB-1:CELL_BITS];
   assign px_cell = req_ff.point_x[CB-1:CELL_BITS];
   assign py_cell = req_ff.point_y[CB-1:CELL_BITS];

   // Clip the far corner to the last cell of the grid.
   assign cx1c = (32'(cx1) >= CELLS_PER_AXIS) ? CW'(CELLS_PER_AXIS - 1) : cx1;
   assign cy1c = (32'(cy1) >= CELLS_PER_AXIS) ? CW'(CELLS_PER_AXIS - 1) : cy1;

   assign mark_addr = AW'(32'(my_ff) * CELLS_PER_AXIS + 32'(mx_ff));
   assign look_addr = AW'(32'(py_cell) * CELLS_PER_AXIS + 32'(px_cell));
   assign rd_addr   = cmd.mark_sel ? mark_addr : look_addr;

   assign xlo = {mx_ff, {CELL_BITS{1'b0}}};
   assign xhi = {mx_ff, {CELL_BITS{1'b1}}};
   assign ylo = {my_ff, {CELL_BITS{1'b0}}};
   assign yhi = {my_ff, {CELL_BITS{1'b1}}};
   assign whole = (xlo >= req_ff.left_edge) && (xhi <= req_ff.right_edge) &&
                  (ylo >= req_ff.top_edge) && (yhi <= req_ff.bottom_edge);

   assign wr_en   = cmd.clr_wr || (cmd.mark_wr && (rd_ff == rri_pkg::EMPTY_MARK));
   assign wr_addr = cmd.clr_wr ? clr_addr_ff : mark_addr;
   assign wr_data = cmd.clr_wr ? rri_pkg::EMPTY_MARK :
                    (whole ? req_ff.region_id : rri_pkg::MIXED_MARK);

   assign ent_dup = (ids_ff[idx_ff] == req_ff.region_id);
   assign ent_ovl = (req_ff.left_edge <= ent.r) && (req_ff.right_edge >= ent.l) &&
                    (req_ff.top_edge <= ent.b) && (req_ff.bottom_edge >= ent.t);

   always_comb begin
      stat.bad_id     = (req_ff.region_id == rri_pkg::EMPTY_MARK) ||
                        (req_ff.region_id == rri_pkg::MIXED_MARK);
      stat.bad_bounds = (req_ff.left_edge > req_ff.right_edge) ||
                        (req_ff.top_edge > req_ff.bottom_edge);
      stat.cnt_zero   = (count_ff == '0);
      stat.full       = (32'(count_ff) >= MAX_RECTS);
      stat.scan_last  = ((NW'(idx_ff) + NW'(1)) == count_ff);
      stat.ent_hit    = (req_ff.point_x >= ent.l) && (req_ff.point_x <= ent.r) &&
                        (req_ff.point_y >= ent.t) && (req_ff.point_y <= ent.b);
      stat.dup_seen   = dup_ff;
      stat.ovl_seen   = ovl_ff;
      stat.clr_last   = (clr_addr_ff == AW'(NUM_CELLS - 1));
      stat.in_grid    = (32'(px_cell) < CELLS_PER_AXIS) && (32'(py_cell) < CELLS_PER_AXIS);
      stat.cell_empty = (rd_ff == rri_pkg::EMPTY_MARK);
      stat.cell_mixed = (rd_ff == rri_pkg::MIXED_MARK);
      stat.mark_skip  = (32'(cx0) >= CELLS_PER_AXIS) || (32'(cy0) >= CELLS_PER_AXIS);
      stat.mark_done  = (mx_ff == cx1c) && (my_ff == cy1c);
   end

   // Control counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.clr_begin) begin
            count_ff    <= '0;
            clr_addr_ff <= '0;
         end else if (cmd.clr_wr) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (cmd.append) begin
            count_ff <= count_ff + NW'(1);
         end
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         dup_ff   <= 1'b0;
         ovl_ff   <= 1'b0;
         found_ff <= 1'b0;
         hit_ff   <= '0;
      end else begin
         if (cmd.scan_acc) begin
            dup_ff <= dup_ff | ent_dup;
            ovl_ff <= ovl_ff | ent_ovl;
         end
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.hit_cell) begin
            found_ff <= 1'b1;
            hit_ff   <= rd_ff;
         end else if (cmd.hit_ent) begin
            found_ff <= 1'b1;
            hit_ff   <= ids_ff[idx_ff];
         end
      end
      if (cmd.append) begin
         bounds_ff[count_ff[IW-1:0]] <= '{l: req_ff.left_edge, r: req_ff.right_edge,
                                          t: req_ff.top_edge, b: req_ff.bottom_edge};
         ids_ff[count_ff[IW-1:0]]    <= req_ff.region_id;
         mx_ff <= cx0;
         my_ff <= cy0;
      end else if (cmd.mark_step) begin
         if (mx_ff == cx1c) begin
            mx_ff <= cx0;
            my_ff <= my_ff + CW'(1);
         end else begin
            mx_ff <= mx_ff + CW'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.found  <= found_ff;
         rsp_ff.hit_id <= hit_ff;
      end
   end

   // Cell map: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      rd_ff <= cell_mem[rd_addr];
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/rri_ctrl.sv
// Controller state machine that sequences clears, registrations and lookups.
`timescale 1ns / 1ps
`default_nettype none
module rri_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_kind,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rri_pkg::stat_type stat,
   output rri_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_CHECK, S_RSCAN, S_RDEC, S_APPEND, S_MRD, S_MWR,
      S_LRD, S_LDEC, S_LSCAN, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       pend_ff, pend_in;
   logic [2:0] fin_ff, fin_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      pend_in      = pend_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               if (pend_ff) begin
                  fin_in   = rri_pkg::ST_OK;
                  pend_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_kind)
                  rri_pkg::KIND_CLEAR: begin
                     cmd.clr_begin = 1'b1;
                     pend_in       = 1'b1;
                     state_in      = S_CLR;
                  end
                  rri_pkg::KIND_REG:    state_in = S_CHECK;
                  rri_pkg::KIND_LOOKUP: state_in = S_LRD;
                  default: begin
                     fin_in   = rri_pkg::ST_OK;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (stat.bad_id) begin
               fin_in   = rri_pkg::ST_RESERVED;
               state_in = S_DONE;
            end else if (stat.bad_bounds) begin
               fin_in   = rri_pkg::ST_BOUNDS;
               state_in = S_DONE;
            end else if (stat.cnt_zero) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_RSCAN;
            end
         end
         S_RSCAN: begin
            cmd.scan_acc = 1'b1;
            if (stat.scan_last) begin
               state_in = S_RDEC;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RDEC: begin
            state_in = S_DONE;
            if (stat.dup_seen) begin
               fin_in = rri_pkg::ST_DUP;
            end else if (stat.ovl_seen) begin
               fin_in = rri_pkg::ST_OVERLAP;
            end else if (stat.full) begin
               fin_in = rri_pkg::ST_FULL;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            fin_in     = rri_pkg::ST_OK;
            state_in   = stat.mark_skip ? S_DONE : S_MRD;
         end
         S_MRD: begin
            cmd.mark_sel = 1'b1;
            state_in     = S_MWR;
         end
         S_MWR: begin
            cmd.mark_sel = 1'b1;
            cmd.mark_wr  = 1'b1;
            if (stat.mark_done) begin
               state_in = S_DONE;
            end else begin
               cmd.mark_step = 1'b1;
               state_in      = S_MRD;
            end
         end
         S_LRD: begin
            state_in = S_LDEC;
         end
         S_LDEC: begin
            fin_in   = rri_pkg::ST_OK;
            state_in = S_DONE;
            if (stat.in_grid && stat.cell_empty) begin
               state_in = S_DONE;
            end else if (stat.in_grid && !stat.cell_mixed) begin
               cmd.hit_cell = 1'b1;
            end else if (!stat.cnt_zero) begin
               state_in = S_LSCAN;
            end
         end
         S_LSCAN: begin
            if (stat.ent_hit) begin
               cmd.hit_ent = 1'b1;
               state_in    = S_DONE;
            end else if (stat.scan_last) begin
               state_in = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = fin_ff;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pend_ff      <= 1'b0;
         fin_ff       <= rri_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: sv/rect_region_index.sv
// Top level of the rectangle region index: controller plus datapath.
// A lookup reads and decodes the cell of its point, then scans the table for a mixed cell
// or a point outside the grid. A registration checks the id and the bounds, scans the stored
// rectangles, then appends the entry and marks its cells. A clear empties the table and the map.
// One item is in work at a time; the next is taken the cycle after the result is registered.
// Reset runs the same clearing pass over every cell of the map, with no item accepted.
`timescale 1ns / 1ps
`default_nettype none
module rect_region_index #(
   parameter int MAX_RECTS      = 16,
   parameter int CELL_BITS      = 6,
   parameter int CELLS_PER_AXIS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rri_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rri_pkg::rsp_type      rsp_data
);

   // The controller steps through the checks, the table scan and the cell
   // marking; the datapath holds the item, the table and the cell map.
   rri_pkg::cmd_type  cmd;
   rri_pkg::stat_type stat;

   rri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The cell map answers full and empty cells; mixed cells and points
   // outside the grid fall back to a scan of the table in stored order.
   rri_dp #(
      .MAX_RECTS      (MAX_RECTS),
      .CELL_BITS      (CELL_BITS),
      .CELLS_PER_AXIS (CELLS_PER_AXIS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: sv/rri_checker.sv
// Port checker of the rectangle region index and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rri_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rri_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted without a busy cycle after it");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == rri_pkg::ST_OK)
      else $error("lookup hit with a nonzero status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.hit_id == '0)
      else $error("hit id set without a hit");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= rri_pkg::ST_FULL)
      else $error("status code out of range");

endmodule

bind rect_region_index rri_checker u_rri_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: test/rect_region_index_checker.sv
// Checker for the rectangle region index: predicts every result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module rect_region_index_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire rri_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire rri_pkg::rsp_type rsp_data,
   output int                    outstanding,
   output int                    mismatches
);

   localparam int TABLE_DEPTH = 16;
   localparam int TILE_BITS   = 6;
   localparam int TILES       = 64;

   rri_pkg::box_type            stored_box [TABLE_DEPTH];
   logic [rri_pkg::ID_BITS-1:0] stored_id  [TABLE_DEPTH];
   int                          stored_count;
   logic [rri_pkg::ID_BITS-1:0] tile_map   [TILES*TILES];
   rri_pkg::rsp_type            predicted_q[$];

   function automatic void clear_index();
      stored_count = 0;
      foreach (tile_map[i]) tile_map[i] = rri_pkg::EMPTY_MARK;
   endfunction

   function automatic void mark_tiles(rri_pkg::box_type bx, logic [rri_pkg::ID_BITS-1:0] id);
      int xlo, ylo, idx;
      bit whole;
      for (int cy = bx.t >> TILE_BITS; cy <= bx.b >> TILE_BITS; cy++) begin
         for (int cx = bx.l >> TILE_BITS; cx <= bx.r >> TILE_BITS; cx++) begin
            idx = cy * TILES + cx;
            if (tile_map[idx] != rri_pkg::EMPTY_MARK) continue;
            xlo = cx << TILE_BITS;
            ylo = cy << TILE_BITS;
            whole = xlo >= bx.l && xlo + (1 << TILE_BITS) - 1 <= bx.r &&
                    ylo >= bx.t && ylo + (1 << TILE_BITS) - 1 <= bx.b;
            tile_map[idx] = whole ? id : rri_pkg::MIXED_MARK;
         end
      end
   endfunction

   function automatic logic [2:0] register_box(rri_pkg::req_type it);
      rri_pkg::box_type bx;
      bx = '{l: it.left_edge, r: it.right_edge, t: it.top_edge, b: it.bottom_edge};
      if (it.region_id == rri_pkg::EMPTY_MARK || it.region_id == rri_pkg::MIXED_MARK)
         return rri_pkg::ST_RESERVED;
      if (bx.l > bx.r || bx.t > bx.b) return rri_pkg::ST_BOUNDS;
      for (int i = 0; i < stored_count; i++)
         if (stored_id[i] == it.region_id) return rri_pkg::ST_DUP;
      for (int i = 0; i < stored_count; i++)
         if (bx.l <= stored_box[i].r && bx.r >= stored_box[i].l &&
             bx.t <= stored_box[i].b && bx.b >= stored_box[i].t) return rri_pkg::ST_OVERLAP;
      if (stored_count >= TABLE_DEPTH) return rri_pkg::ST_FULL;
      stored_box[stored_count] = bx;
      stored_id[stored_count]  = it.region_id;
      stored_count++;
      mark_tiles(bx, it.region_id);
      return rri_pkg::ST_OK;
   endfunction

   function automatic rri_pkg::rsp_type locate_point(rri_pkg::req_type it);
      rri_pkg::rsp_type            res;
      logic [rri_pkg::ID_BITS-1:0] code;
      res  = '0;
      code = tile_map[{it.point_y[11:6], it.point_x[11:6]}];
      if (code == rri_pkg::EMPTY_MARK) return res;
      res.found = 1'b1;
      if (code != rri_pkg::MIXED_MARK) begin
         res.hit_id = code;
         return res;
      end
      for (int i = 0; i < stored_count; i++) begin
         if (it.point_x >= stored_box[i].l && it.point_x <= stored_box[i].r &&
             it.point_y >= stored_box[i].t && it.point_y <= stored_box[i].b) begin
            res.hit_id = stored_id[i];
            return res;
         end
      end
      return '0;
   endfunction

   function automatic rri_pkg::rsp_type predict_result(rri_pkg::req_type it);
      rri_pkg::rsp_type res;
      res = '0;
      case (it.kind)
         rri_pkg::KIND_CLEAR:  clear_index();
         rri_pkg::KIND_REG:    res.status = register_box(it);
         rri_pkg::KIND_LOOKUP: res = locate_point(it);
         default:     ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rri_pkg::rsp_type want;
      if (reset) begin
         clear_index();
         predicted_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               $error("result arrived with nothing outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.hit_id !== want.hit_id) begin
                  $error("hit_id: expected %0d, got %0d", want.hit_id, rsp_data.hit_id);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            predicted_q.insert(predicted_q.size(), predict_result(req_data));
      end
      outstanding = predicted_q.size();
   end

endmodule
`default_nettype wire

FILE: test/rect_region_index_tb.sv
// Testbench top for the rectangle region index: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
`default_nettype none
module rect_region_index_tb;

   // Clears and the reset clearing pass each write all 4096 cells, so the limit
   // leaves ample room for a few dozen clears plus occasional large rectangles.
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES  = 400;

   // The one kind code that the block treats as a no-op.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rri_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rri_pkg::rsp_type rsp_data;
   int               outstanding;
   int               mismatches;
   int               cycle_count = 0;

   // Sender burst bookkeeping and the request for a long receiver hold-off.
   int               burst_left = 0;
   bit               hold_request = 0;
   rri_pkg::box_type recent_boxes[$];

   always #2 clock = ~clock;

   rect_region_index uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   rect_region_index_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .outstanding(outstanding), .mismatches(mismatches)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rect_region_index verification failed");
         $finish;
      end
   end

   // The receiver switches between free running, light and heavy stalling,
   // and honors a request for one long hold-off that it counts itself.
   always @(negedge clock) begin
      static int hold_left = 0;
      static int phase_left = 0;
      static int stall_mode = 0;
      if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 200);
         end else begin
            phase_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Every field that the kind does not use carries random noise.
   function automatic rri_pkg::req_type make_item(logic [1:0] kind, int id, int l, int r,
                                                  int t, int b, int x, int y);
      rri_pkg::req_type it;
      logic [95:0]      noise;
      noise          = {$urandom, $urandom, $urandom};
      it             = noise[$bits(rri_pkg::req_type)-1:0];
      it.kind        = kind;
      if (id >= 0) it.region_id = 8'(id);
      if (l >= 0) begin
         it.left_edge   = 12'(l);
         it.right_edge  = 12'(r);
         it.top_edge    = 12'(t);
         it.bottom_edge = 12'(b);
      end
      if (x >= 0) begin
         it.point_x = 12'(x);
         it.point_y = 12'(y);
      end
      return it;
   endfunction

   // Offers one item and holds it until it is taken. Between bursts the
   // sender drops valid for a random gap.
   task automatic offer_item(rri_pkg::req_type it);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      if (it.kind == rri_pkg::KIND_CLEAR) recent_boxes.delete();
      else if (it.kind == rri_pkg::KIND_REG && it.left_edge <= it.right_edge) begin
         recent_boxes.insert(recent_boxes.size(),
                             '{l: it.left_edge, r: it.right_edge,
                               t: it.top_edge, b: it.bottom_edge});
         if (recent_boxes.size() > 24) void'(recent_boxes.pop_front());
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // A random rectangle: mostly small, sometimes aligned to whole tiles,
   // rarely huge, and now and then with inverted bounds.
   function automatic rri_pkg::req_type random_region();
      int l, t, w, h, sel, id;
      sel = $urandom_range(0, 99);
      id  = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 40);
      if ($urandom_range(0, 29) == 0) id = $urandom_range(254, 255);
      if (sel < 15) begin
         l = $urandom_range(0, 63) * 64;
         t = $urandom_range(0, 63) * 64;
         w = $urandom_range(1, 3) * 64 - 1;
         h = $urandom_range(1, 3) * 64 - 1;
      end else if (sel < 17) begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         w = $urandom_range(0, 4095);
         h = $urandom_range(0, 4095);
      end else begin
         l = $urandom_range(0, 4095);
         t = $urandom_range(0, 4095);
         w = $urandom_range(0, 100);
         h = $urandom_range(0, 100);
      end
      if (sel >= 93)
         return make_item(rri_pkg::KIND_REG, id, l, $urandom_range(0, 4095),
                          t, $urandom_range(0, 4095), -1, 0);
      return make_item(rri_pkg::KIND_REG, id, l, l + w > 4095 ? 4095 : l + w,
                       t, t + h > 4095 ? 4095 : t + h, -1, 0);
   endfunction

   // Lookups aim mostly at or just around recently registered rectangles.
   function automatic rri_pkg::req_type random_lookup();
      rri_pkg::box_type bx;
      int x, y;
      if (recent_boxes.size() == 0 || $urandom_range(0, 9) < 3)
         return make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0,
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
      bx = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
      x  = $urandom_range(bx.l, bx.r) + ($urandom_range(0, 3) == 0 ? 1 : 0);
      y  = $urandom_range(bx.t, bx.b) - ($urandom_range(0, 3) == 0 ? 1 : 0);
      if (x > 4095) x = 4095;
      if (y < 0) y = 0;
      return make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, x, y);
   endfunction

   initial begin
      int sel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every status, the reserved ids, the unused kind,
      // a full-width rectangle seen through mixed tiles, whole tiles
      // answered straight from the map, and a full table.
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 0, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 255, 0, 10, 0, 10, -1, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 254, 0, 10, 0, 10, -1, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 5, 10, 9, 0, 10, -1, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 5, 0, 10, 4095, 0, -1, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 0, 0, 4095, 0, 0, -1, 0));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 4095, 0));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 4095, 1));
      offer_item(make_item(rri_pkg::KIND_REG, 0, 500, 600, 500, 600, -1, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 7, 100, 200, 0, 5, -1, 0));
      offer_item(make_item(KIND_SPARE, -1, -1, 0, 0, 0, -1, 0));
      offer_item(make_item(rri_pkg::KIND_CLEAR, -1, -1, 0, 0, 0, -1, 0));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 4095, 0));
      offer_item(make_item(rri_pkg::KIND_REG, 9, 64, 191, 64, 191, -1, 0));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 100, 100));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 63, 63));
      for (int i = 0; i < 15; i++) begin
         offer_item(make_item(rri_pkg::KIND_REG, 10 + i, 256 + i * 128, 300 + i * 128,
                              3000, 4095, -1, 0));
      end
      offer_item(make_item(rri_pkg::KIND_REG, 30, 0, 0, 0, 0, -1, 0));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 4095, 4095));
      offer_item(make_item(rri_pkg::KIND_LOOKUP, -1, -1, 0, 0, 0, 2048, 3500));
      offer_item(make_item(rri_pkg::KIND_CLEAR, -1, -1, 0, 0, 0, -1, 0));

      // Random part, with one long receiver hold-off and one full drain.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) hold_request = 1;
         if (n == 2 * RANDOM_ITEMS / 3) wait_drained();
         sel = $urandom_range(0, 199);
         if (sel < 3)
            offer_item(make_item(rri_pkg::KIND_CLEAR, -1, -1, 0, 0, 0, -1, 0));
         else if (sel < 8)  offer_item(make_item(KIND_SPARE, -1, -1, 0, 0, 0, -1, 0));
         else if (sel < 80) offer_item(random_region());
         else               offer_item(random_lookup());
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("rect_region_index verification clean");
      end else begin
         $display("rect_region_index verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
sv/rri_pkg.sv
sv/rri_dp.sv
sv/rri_ctrl.sv
sv/rect_region_index.sv
sv/rri_checker.sv
test/rect_region_index_checker.sv
test/rect_region_index_tb.sv
